[src/dts_pkg.sv]
// Shared constants, token types and queue entry layout for the Datalog token scanner.
package dts_pkg;

   // Field widths of the token stream.
   localparam int LINE_WIDTH   = 16;
   localparam int LENGTH_WIDTH = 12;

   // Depth of the queue between the classifier and the token sender.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;

   typedef enum logic [4:0] {
      KIND_QUERIES       = 5'd0,
      KIND_RULES         = 5'd1,
      KIND_FACTS         = 5'd2,
      KIND_SCHEMES       = 5'd3,
      KIND_ID            = 5'd4,
      KIND_ADD           = 5'd5,
      KIND_MULTIPLY      = 5'd6,
      KIND_COLON         = 5'd7,
      KIND_COLON_DASH    = 5'd8,
      KIND_LPAREN        = 5'd9,
      KIND_RPAREN        = 5'd10,
      KIND_QMARK         = 5'd11,
      KIND_PERIOD        = 5'd12,
      KIND_COMMA         = 5'd13,
      KIND_COMMENT       = 5'd14,
      KIND_BLOCK_COMMENT = 5'd15,
      KIND_UNDEFINED     = 5'd16,
      KIND_EOF           = 5'd17
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [LINE_WIDTH-1:0]     line;
      logic [LENGTH_WIDTH-1:0]   text_length;
   } token_type;

   // One classified request: one or two tokens.
   typedef struct packed {
      token_type first;
      token_type second;
      logic      pair;
   } entry_type;

endpackage

[src/dts_if.sv]
// Valid/ready channel interfaces for scanner requests and tokens.
interface dts_req_if
   import dts_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface dts_rsp_if
   import dts_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [4:0]              kind;
   logic [LINE_WIDTH-1:0]   line;
   logic [LENGTH_WIDTH-1:0] text_length;
   logic                    last;

   modport source (output valid, output kind, output line, output text_length, output last,
                   input ready);
   modport sink   (input valid, input kind, input line, input text_length, input last,
                   output ready);
endinterface

[src/dts_front.sv]
// Classifier: per-character lexer state update producing up to two tokens per request.
module dts_front
   import dts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dts_req_if.sink   req,
   output logic      push_valid,
   output entry_type push_entry,
   input  logic      push_ready
);

   typedef enum logic [6:0] {
      MODE_IDLE  = 7'b0000001,
      MODE_IDENT = 7'b0000010,
      MODE_COLON = 7'b0000100,
      MODE_HASH  = 7'b0001000,
      MODE_LINE  = 7'b0010000,
      MODE_BLOCK = 7'b0100000,
      MODE_BAR   = 7'b1000000
   } mode_type;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_QMARK   = 8'h3F;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   localparam logic [7:0] KW_CHAR [0:3][0:7] = '{
      '{8'h51, 8'h75, 8'h65, 8'h72, 8'h69, 8'h65, 8'h73, 8'h00},   // Queries
      '{8'h52, 8'h75, 8'h6C, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},   // Rules
      '{8'h46, 8'h61, 8'h63, 8'h74, 8'h73, 8'h00, 8'h00, 8'h00},   // Facts
      '{8'h53, 8'h63, 8'h68, 8'h65, 8'h6D, 8'h65, 8'h73, 8'h00}    // Schemes
   };
   localparam logic [3:0] KW_LEN [0:3] = '{4'd7, 4'd5, 4'd5, 4'd7};

   function automatic logic [LENGTH_WIDTH-1:0] sat_inc(input logic [LENGTH_WIDTH-1:0] v);
      sat_inc = (v == LEN_MAX) ? LEN_MAX : v + 1'b1;
   endfunction

   // Drops every keyword whose character at this position differs from c.
   function automatic logic [3:0] kw_track(input logic [3:0] alive,
                                           input logic [LENGTH_WIDTH-1:0] pos,
                                           input logic [7:0] c);
      logic [3:0] res;
      res = alive;
      for (int k = 0; k < 4; k++) begin
         if (pos >= LENGTH_WIDTH'(KW_LEN[k]) || KW_CHAR[k][pos[2:0]] != c) begin
            res[k] = 1'b0;
         end
      end
      kw_track = res;
   endfunction

   function automatic token_type make_tok(input kind_type kind,
                                          input logic [LINE_WIDTH-1:0] line,
                                          input logic [LENGTH_WIDTH-1:0] len);
      token_type t;
      t.kind        = kind;
      t.line        = line;
      t.text_length = len;
      make_tok      = t;
   endfunction

   mode_type                mode_ff,  mode_in;
   logic [LINE_WIDTH-1:0]   line_ff,  line_in;
   logic [LINE_WIDTH-1:0]   start_ff, start_in;
   logic [LENGTH_WIDTH-1:0] run_ff,   run_in;
   logic [3:0]              alive_ff, alive_in;

   logic                    accept;
   logic [7:0]              c;
   logic                    is_alpha;
   logic                    is_digit;
   logic                    is_space;
   logic [LINE_WIDTH-1:0]   line_inc;
   token_type               ident_tok;
   kind_type                ident_kind;
   token_type               tok_a;
   token_type               tok_b;
   token_type               extra_tok;
   logic                    extra_emit;
   logic                    redo;
   logic [1:0]              n;

   assign c        = req.ch;
   assign accept   = req.valid && push_ready;
   assign req.ready = push_ready;
   assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   assign is_digit = (c >= 8'h30 && c <= 8'h39);
   assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   assign line_inc = (line_ff == LINE_MAX) ? LINE_MAX : line_ff + 1'b1;

   // First live keyword of matching length wins; a saturated run is never a keyword.
   always_comb begin
      ident_kind = KIND_ID;
      for (int k = 3; k >= 0; k--) begin
         if (alive_ff[k] && run_ff == LENGTH_WIDTH'(KW_LEN[k]) && run_ff != LEN_MAX) begin
            ident_kind = kind_type'(5'(k));
         end
      end
      ident_tok = make_tok(ident_kind, start_ff, run_ff);
   end

   always_comb begin
      mode_in    = mode_ff;
      line_in    = line_ff;
      start_in   = start_ff;
      run_in     = run_ff;
      alive_in   = alive_ff;
      tok_a      = make_tok(KIND_EOF, line_ff, '0);
      tok_b      = tok_a;
      n          = 2'd0;
      redo       = 1'b0;
      extra_emit = 1'b0;
      extra_tok  = tok_a;

      if (req.end_of_input) begin
         case (mode_ff)
            MODE_IDENT: begin
               tok_a = ident_tok;
               n     = 2'd1;
            end
            MODE_COLON: begin
               tok_a = make_tok(KIND_COLON, start_ff, LENGTH_WIDTH'(1));
               n     = 2'd1;
            end
            MODE_HASH, MODE_LINE: begin
               tok_a = make_tok(KIND_COMMENT, start_ff, run_ff);
               n     = 2'd1;
            end
            MODE_BLOCK, MODE_BAR: begin
               tok_a = make_tok(KIND_UNDEFINED, start_ff, run_ff);
               n     = 2'd1;
            end
            default: begin
            end
         endcase
         extra_emit = 1'b1;
         extra_tok  = make_tok(KIND_EOF, line_ff, '0);
         mode_in    = MODE_IDLE;
         run_in     = '0;
         alive_in   = '1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  alive_in = kw_track(alive_ff, run_ff, c);
                  run_in   = sat_inc(run_ff);
               end else begin
                  tok_a = ident_tok;
                  n     = 2'd1;
                  redo  = 1'b1;
               end
            end
            MODE_COLON: begin
               if (c == CH_DASH) begin
                  tok_a   = make_tok(KIND_COLON_DASH, start_ff, LENGTH_WIDTH'(2));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  tok_a = make_tok(KIND_COLON, start_ff, LENGTH_WIDTH'(1));
                  n     = 2'd1;
                  redo  = 1'b1;
               end
            end
            MODE_HASH, MODE_LINE: begin
               if (mode_ff == MODE_HASH && c == CH_BAR) begin
                  run_in  = sat_inc(run_ff);
                  mode_in = MODE_BLOCK;
               end else if (c == CH_NEWLINE) begin
                  tok_a   = make_tok(KIND_COMMENT, start_ff, run_ff);
                  n       = 2'd1;
                  line_in = line_inc;
                  mode_in = MODE_IDLE;
               end else begin
                  run_in  = sat_inc(run_ff);
                  mode_in = MODE_LINE;
               end
            end
            MODE_BLOCK, MODE_BAR: begin
               run_in = sat_inc(run_ff);
               if (mode_ff == MODE_BAR && c == CH_HASH) begin
                  tok_a   = make_tok(KIND_BLOCK_COMMENT, start_ff, sat_inc(run_ff));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (c == CH_BAR) begin
                  mode_in = MODE_BAR;
               end else begin
                  if (c == CH_NEWLINE) begin
                     line_in = line_inc;
                  end
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               redo = 1'b1;
            end
         endcase

         // Character handled from idle, possibly after a token it ended.
         if (redo) begin
            mode_in  = MODE_IDLE;
            start_in = line_ff;
            if (is_alpha) begin
               alive_in = kw_track(4'hF, '0, c);
               run_in   = LENGTH_WIDTH'(1);
               mode_in  = MODE_IDENT;
            end else begin
               case (c)
                  CH_PLUS: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_ADD, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_STAR: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_MULTIPLY, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_LPAREN: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_LPAREN, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_RPAREN: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_RPAREN, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_QMARK: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_QMARK, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_PERIOD: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_PERIOD, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_COMMA: begin
                     extra_emit = 1'b1;
                     extra_tok  = make_tok(KIND_COMMA, line_ff, LENGTH_WIDTH'(1));
                  end
                  CH_COLON: begin
                     mode_in = MODE_COLON;
                     run_in  = LENGTH_WIDTH'(1);
                  end
                  CH_HASH: begin
                     mode_in = MODE_HASH;
                     run_in  = LENGTH_WIDTH'(1);
                  end
                  CH_NEWLINE: begin
                     line_in = line_inc;
                  end
                  default: begin
                     if (!is_space) begin
                        extra_emit = 1'b1;
                        extra_tok  = make_tok(KIND_UNDEFINED, line_ff, LENGTH_WIDTH'(1));
                     end
                  end
               endcase
            end
         end
      end

      if (extra_emit) begin
         if (n == 2'd0) begin
            tok_a = extra_tok;
         end else begin
            tok_b = extra_tok;
         end
         n = n + 2'd1;
      end
   end

   assign push_valid       = accept && (n != 2'd0);
   assign push_entry.first  = tok_a;
   assign push_entry.second = tok_b;
   assign push_entry.pair   = (n == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= LINE_WIDTH'(1);
         start_ff <= LINE_WIDTH'(1);
         run_ff   <= '0;
         alive_ff <= '1;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         alive_ff <= alive_in;
      end
   end

endmodule

[src/dts_queue.sv]
// Small FIFO of classified requests between the classifier and the token sender.
module dts_queue
   import dts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop_ready
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff,  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/dts_back.sv]
// Token sender: drains queue entries and delivers their tokens, one per cycle while the receiver is ready.
module dts_back
   import dts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop_ready,
   dts_rsp_if.source rsp
);

   logic      out_valid_ff;
   token_type out_tok_ff;
   logic      out_last_ff;
   logic      hold_ff;
   token_type held_tok_ff;
   logic      load;

   assign load      = !out_valid_ff || rsp.ready;
   assign pop_ready = load && !hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         hold_ff      <= 1'b0;
      end else if (load) begin
         if (hold_ff) begin
            out_valid_ff <= 1'b1;
            hold_ff      <= 1'b0;
         end else begin
            out_valid_ff <= pop_valid;
            hold_ff      <= pop_valid && pop_entry.pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (hold_ff) begin
            out_tok_ff  <= held_tok_ff;
            out_last_ff <= 1'b1;
         end else if (pop_valid) begin
            out_tok_ff  <= pop_entry.first;
            out_last_ff <= !pop_entry.pair;
            held_tok_ff <= pop_entry.second;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_tok_ff.kind;
   assign rsp.line        = out_tok_ff.line;
   assign rsp.text_length = out_tok_ff.text_length;
   assign rsp.last        = out_last_ff;

endmodule

[src/datalog_token_scanner_unit.sv]
// Datalog token scanner: one source character per request in, typed tokens out.
//
// The req_port channel carries one request per character: ch and end_of_input.
// Each request yields zero, one or two tokens on rsp_port, each with its kind,
// the line on which it starts and its saturating text length; last marks the
// final token caused by a request. A request that ends an identifier or a
// colon gives that token and, in the same request, whatever the ending
// character starts. End of input flushes the pending token, then sends the
// end-of-file token.
// A classifier updates the lexer state in the cycle a request is accepted and
// writes the resulting tokens as one entry into a four-entry queue. A sender
// pops entries and drives a registered output, one token per cycle while the
// receiver is ready. A token passes through the queue and then the output
// register before it is offered. The block takes one request per cycle while
// the queue has room; a request with two tokens holds the output for both of
// them, and the queue absorbs such bursts.
// When the receiver stalls, the output token holds and the queue fills; the
// request channel drops ready only when the queue is full.
// Reset (synchronous) clears the queue and output, sets line counting to one
// and returns the lexer to its idle mode.
module datalog_token_scanner_unit
   import dts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dts_req_if.sink   req_port,
   dts_rsp_if.source rsp_port
);

   logic      push_valid;
   entry_type push_entry;
   logic      push_ready;
   logic      pop_valid;
   entry_type pop_entry;
   logic      pop_ready;

   // Classify each character and compute its tokens.
   dts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Decouple classification from token delivery.
   dts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // Serialize token pairs onto the output channel.
   dts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp       (rsp_port)
   );

endmodule

[src/dts_checker.sv]
// Port-level checks on the token stream of the scanner, bound to the top level.
module dts_checker
   import dts_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [4:0]              rsp_kind,
   input logic [LINE_WIDTH-1:0]   rsp_line,
   input logic [LENGTH_WIDTH-1:0] rsp_text_length,
   input logic                    rsp_last
);

   // No token is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token offered after reset");

   // A stalled token keeps its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_line)
                                  && $stable(rsp_text_length) && $stable(rsp_last))
      else $error("stalled token changed");

   // The end-of-file token closes its request and carries no text.
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EOF |-> rsp_last && rsp_text_length == '0)
      else $error("end-of-file token not last or has text");

   // The second token of a pair follows its first without a gap.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second token of a pair missing");

   // Line numbers start at one and never wrap to zero.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line != '0)
      else $error("token with line zero");

endmodule

bind datalog_token_scanner_unit dts_checker u_dts_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_kind        (rsp_port.kind),
   .rsp_line        (rsp_port.line),
   .rsp_text_length (rsp_port.text_length),
   .rsp_last        (rsp_port.last)
);

[bench/dts_token_checker.sv]
// Token predictor and comparator that watches both channels of the Datalog token scanner.
module dts_token_checker
   import dts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dts_req_if   req_mon,
   dts_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_COLON,
      SCAN_HASH,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_BAR
   } scan_mode_type;

   typedef struct {
      kind_type                kind;
      logic [LINE_WIDTH-1:0]   line;
      logic [LENGTH_WIDTH-1:0] text_length;
      logic                    last;
   } token_expect_type;

   string    keywords[4]      = '{"Queries", "Rules", "Facts", "Schemes"};
   kind_type keyword_kinds[4] = '{KIND_QUERIES, KIND_RULES, KIND_FACTS, KIND_SCHEMES};

   scan_mode_type           mode;
   logic [LINE_WIDTH-1:0]   line_count;
   logic [LINE_WIDTH-1:0]   start_line;
   logic [LENGTH_WIDTH-1:0] run_length;
   logic [3:0]              keyword_alive;

   token_expect_type pending_tokens[$];
   token_expect_type step_tokens[$];
   int               failures = 0;
   int               waiting  = 0;

   assign fail_count  = failures;
   assign outstanding = waiting;

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [LENGTH_WIDTH-1:0] bump(logic [LENGTH_WIDTH-1:0] v);
      return (v == LEN_MAX) ? v : v + 1'b1;
   endfunction

   function automatic void add_token(kind_type kind, logic [LINE_WIDTH-1:0] line,
                                     logic [LENGTH_WIDTH-1:0] text_length);
      token_expect_type t;
      t.kind        = kind;
      t.line        = line;
      t.text_length = text_length;
      t.last        = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void count_line();
      if (line_count != LINE_MAX) line_count = line_count + 1'b1;
   endfunction

   // Drops every keyword whose character at the current position differs.
   function automatic void match_keywords(logic [7:0] c);
      for (int k = 0; k < 4; k++) begin
         if (run_length >= keywords[k].len() || keywords[k][run_length] != c)
            keyword_alive[k] = 1'b0;
      end
   endfunction

   function automatic void emit_identifier();
      kind_type kind;
      kind = KIND_ID;
      for (int k = 0; k < 4; k++) begin
         if (keyword_alive[k] && run_length == keywords[k].len() && run_length != LEN_MAX) begin
            kind = keyword_kinds[k];
            break;
         end
      end
      add_token(kind, start_line, run_length);
   endfunction

   function automatic void start_char(logic [7:0] c);
      mode       = SCAN_IDLE;
      start_line = line_count;
      if (is_letter(c)) begin
         keyword_alive = '1;
         run_length    = '0;
         match_keywords(c);
         run_length = 1;
         mode       = SCAN_IDENT;
         return;
      end
      case (c)
         "+": add_token(KIND_ADD, line_count, 1);
         "*": add_token(KIND_MULTIPLY, line_count, 1);
         "(": add_token(KIND_LPAREN, line_count, 1);
         ")": add_token(KIND_RPAREN, line_count, 1);
         "?": add_token(KIND_QMARK, line_count, 1);
         ".": add_token(KIND_PERIOD, line_count, 1);
         ",": add_token(KIND_COMMA, line_count, 1);
         ":": begin
            mode       = SCAN_COLON;
            run_length = 1;
         end
         "#": begin
            mode       = SCAN_HASH;
            run_length = 1;
         end
         "\n": count_line();
         default: begin
            if (!is_blank(c)) add_token(KIND_UNDEFINED, line_count, 1);
         end
      endcase
   endfunction

   function automatic void scan_char(logic [7:0] c, logic end_of_input);
      step_tokens.delete();
      if (end_of_input) begin
         case (mode)
            SCAN_IDENT: emit_identifier();
            SCAN_COLON: add_token(KIND_COLON, start_line, 1);
            SCAN_HASH, SCAN_LINE: add_token(KIND_COMMENT, start_line, run_length);
            SCAN_BLOCK, SCAN_BAR: add_token(KIND_UNDEFINED, start_line, run_length);
            default: ;
         endcase
         add_token(KIND_EOF, line_count, '0);
         mode          = SCAN_IDLE;
         run_length    = '0;
         keyword_alive = '1;
      end else begin
         case (mode)
            SCAN_IDENT: begin
               if (is_letter(c) || is_digit(c)) begin
                  match_keywords(c);
                  run_length = bump(run_length);
               end else begin
                  emit_identifier();
                  start_char(c);
               end
            end
            SCAN_COLON: begin
               if (c == "-") begin
                  add_token(KIND_COLON_DASH, start_line, 2);
                  mode = SCAN_IDLE;
               end else begin
                  add_token(KIND_COLON, start_line, 1);
                  start_char(c);
               end
            end
            SCAN_HASH, SCAN_LINE: begin
               if (mode == SCAN_HASH && c == "|") begin
                  run_length = bump(run_length);
                  mode       = SCAN_BLOCK;
               end else if (c == "\n") begin
                  add_token(KIND_COMMENT, start_line, run_length);
                  count_line();
                  mode = SCAN_IDLE;
               end else begin
                  run_length = bump(run_length);
                  mode       = SCAN_LINE;
               end
            end
            SCAN_BLOCK, SCAN_BAR: begin
               run_length = bump(run_length);
               if (mode == SCAN_BAR && c == "#") begin
                  add_token(KIND_BLOCK_COMMENT, start_line, run_length);
                  mode = SCAN_IDLE;
               end else if (c == "|") begin
                  mode = SCAN_BAR;
               end else begin
                  if (c == "\n") count_line();
                  mode = SCAN_BLOCK;
               end
            end
            default: start_char(c);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
   endfunction

   always @(posedge clock) begin
      token_expect_type want;
      if (reset) begin
         mode          = SCAN_IDLE;
         line_count    = 1;
         start_line    = 1;
         run_length    = '0;
         keyword_alive = '1;
         pending_tokens.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_tokens.size() == 0) begin
               $error("unexpected token: kind %0d line %0d text_length %0d last %0d",
                      rsp_mon.kind, rsp_mon.line, rsp_mon.text_length, rsp_mon.last);
               failures++;
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_mon.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_mon.kind);
                  failures++;
               end
               if (rsp_mon.line !== want.line) begin
                  $error("line: expected %0d, actual %0d", want.line, rsp_mon.line);
                  failures++;
               end
               if (rsp_mon.text_length !== want.text_length) begin
                  $error("text_length: expected %0d, actual %0d",
                         want.text_length, rsp_mon.text_length);
                  failures++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_mon.last);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) scan_char(req_mon.ch, req_mon.end_of_input);
      end
      waiting = pending_tokens.size();
   end

endmodule

[bench/tb_datalog_token_scanner_unit.sv]
// Testbench top for the Datalog token scanner: stimulus, receiver pacing, watchdog and verdict.
module tb_datalog_token_scanner_unit;

   // Number of requests after which the random part stops.
   localparam int RANDOM_REQUESTS = 600;
   // Length of the single long receiver hold-off that fills the internal queue.
   localparam int HOLD_OFF_CYCLES = 200;
   // The watchdog fires after this many cycles with no request or token accepted.
   // The longest legal quiet stretch is the hold-off plus one long gap, far below it.
   localparam int WATCHDOG_LIMIT = 2000;
   // Wait before the verdict; a token passes the queue and the output register first.
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset;

   // Shared pacing controls: steady turns off idling on both sides, and
   // hold_off_due asks the receiver for its one long stall.
   bit steady       = 1'b0;
   bit hold_off_due = 1'b0;
   bit hold_off_set = 1'b0;
   int requests_sent = 0;
   int fail_count;
   int outstanding;

   string keywords[4] = '{"Queries", "Rules", "Facts", "Schemes"};
   logic [7:0] blanks[6] = '{8'd32, 8'd9, 8'd10, 8'd13, 8'd11, 8'd12};
   logic [7:0] punctuation[7] = '{"+", "*", "(", ")", "?", ".", ","};
   logic [7:0] separators[6] = '{" ", "\n", "(", ",", ".", ")"};

   dts_req_if req_if ();
   dts_rsp_if rsp_if ();

   datalog_token_scanner_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // The checker watches both channels, predicts every token and compares.
   dts_token_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle lengths: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] random_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'(65 + r) : 8'(71 + r);
   endfunction

   function automatic logic [7:0] random_alnum();
      int r;
      r = $urandom_range(0, 61);
      return (r < 10) ? 8'(48 + r) : ((r < 36) ? 8'(55 + r) : 8'(61 + r));
   endfunction

   // Offers one request and returns once it is accepted and any idle gap after
   // it is over. The valid line stays high into the next request unless an idle
   // gap follows, so it is never lowered and raised within one time step.
   task automatic push_request(input logic [7:0] c, input logic end_of_input);
      int gap;
      req_if.valid        <= 1'b1;
      req_if.ch           <= c;
      req_if.end_of_input <= end_of_input;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_request(s[i], 1'b0);
   endtask

   // The character byte is random on an end request; the block must ignore it.
   task automatic send_end();
      push_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_separator();
      push_request(separators[$urandom_range(0, 5)], 1'b0);
   endtask

   // One random piece of source text. Most pieces are well-formed tokens with
   // random content; some are stray bytes, early ends and unterminated tokens.
   task automatic send_fragment();
      string word;
      int    n;
      int    r;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            // A keyword exactly, cut short, or with extra characters appended.
            word = keywords[$urandom_range(0, 3)];
            r = $urandom_range(0, 3);
            if (r == 1) word = word.substr(0, $urandom_range(0, word.len() - 2));
            send_text(word);
            if (r == 2) repeat ($urandom_range(1, 3)) push_request(random_alnum(), 1'b0);
            if ($urandom_range(0, 4) != 0) send_separator();
         end
         3, 4: begin
            push_request(random_letter(), 1'b0);
            repeat ($urandom_range(0, 8)) push_request(random_alnum(), 1'b0);
            if ($urandom_range(0, 4) != 0) send_separator();
         end
         5, 6, 7: push_request(punctuation[$urandom_range(0, 6)], 1'b0);
         8: send_text(":-");
         // A lone colon: whatever piece comes next decides what follows it.
         9: push_request(":", 1'b0);
         10, 11: repeat ($urandom_range(1, 3)) push_request(blanks[$urandom_range(0, 5)], 1'b0);
         12: begin
            push_request("#", 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) push_request(8'($urandom_range(32, 126)), 1'b0);
            if ($urandom_range(0, 6) == 0) send_end();
            else push_request("\n", 1'b0);
         end
         13: begin
            // Block comment body mixes bars, hashes and newlines.
            send_text("#|");
            repeat ($urandom_range(0, 12)) begin
               r = $urandom_range(0, 19);
               if (r < 2) push_request("|", 1'b0);
               else if (r < 4) push_request("\n", 1'b0);
               else if (r < 5) push_request("#", 1'b0);
               else push_request(random_alnum(), 1'b0);
            end
            if ($urandom_range(0, 6) == 0) send_end();
            else send_text("|#");
         end
         14, 15: push_request(8'($urandom_range(0, 255)), 1'b0);
         16: send_end();
         default: begin
            // A short clause in the language's own shape.
            send_text(keywords[$urandom_range(0, 3)]);
            send_text(":\n  a(");
            push_request(random_letter(), 1'b0);
            send_text(",B) :- c(x)?.\n");
         end
      endcase
   endtask

   // Receiver pacing. It runs in its own process so that the long hold-off is
   // counted here while the sender keeps offering requests.
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.ch           <= 8'h00;
      req_if.end_of_input <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a keyword ended by punctuation, every single-character
      // token, colon-dash, a colon followed by another character, a line
      // comment, an empty block comment, the lowest and highest bytes and a
      // byte above the printable range. Then an end, a lone hash and another end.
      send_text("Facts+*():-a:?.,#c\n#||#");
      push_request(8'h00, 1'b0);
      push_request(8'hFF, 1'b0);
      push_request(8'h80, 1'b0);
      send_end();
      send_text("#");
      send_end();

      // Random part, with one long receiver stall early on and a window
      // without any idling on either side.
      while (requests_sent < RANDOM_REQUESTS) begin
         if (!hold_off_set && requests_sent > 150) begin
            hold_off_set = 1'b1;
            hold_off_due = 1'b1;
         end
         steady = (requests_sent > 350 && requests_sent < 450);
         send_fragment();
      end

      // Closing part: a keyword, a parenthesis, a block comment that spans a
      // line, an identifier and the end.
      send_text("Rules ) #|x\n|#\nq");
      send_end();
      req_if.valid <= 1'b0;

      // Wait for every predicted token, then give the pipeline time to show
      // any token that should not be there.
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
